/* src/lavm_pkg.sv */
// constants shared by the look-at view matrix pipeline and its normalize unit
// no dependencies
package lavm_pkg;

    // stream payload widths
    localparam int IN_W   = 288;
    localparam int OUT_W  = 264;
    localparam int CW     = 32;

    // normalize unit widths
    localparam int VW       = 50;
    localparam int MW       = 49;
    localparam int PW       = 6;
    localparam int NW       = 30;
    localparam int NTOP     = 29;
    localparam int SW       = 64;
    localparam int SQ_STEPS = 32;
    localparam int LW       = 31;
    localparam int DW       = 32;
    localparam int RW       = 48;
    localparam int QB       = 17;
    localparam int UW       = 18;

    // input register, leading one, shift, squares, sum, root steps,
    // divide setup, divide steps, output register
    localparam int NORM_LAT = 5 + SQ_STEPS + 1 + QB + 1;

endpackage

/* src/lavm_norm.sv */
// pipelined vector normalize: leading one search, shift, squares, root, divide
// depends on lavm_pkg
module lavm_norm (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               in_valid,
    input  logic signed [lavm_pkg::VW-1:0]     in_vec [3],
    output logic                               out_valid,
    output logic signed [lavm_pkg::UW-1:0]     out_vec [3]
);
    import lavm_pkg::*;

    logic              vld_reg [NORM_LAT];

    logic [MW-1:0]     mag_a_next [3];
    logic [MW-1:0]     mag_a_reg  [3];
    logic              neg_a_reg  [3];

    logic [MW-1:0]     or_a;
    logic [PW-1:0]     pos_b_next;
    logic [PW-1:0]     pos_b_reg;
    logic              zero_b_reg;
    logic [MW-1:0]     mag_b_reg  [3];
    logic              neg_b_reg  [3];

    logic [MW-1:0]     shf_c      [3];
    logic [NW-1:0]     nm_c_reg   [3];
    logic              neg_c_reg  [3];
    logic              zero_c_reg;

    logic [2*NW-1:0]   sqr_d_reg  [3];
    logic [NW-1:0]     nm_d_reg   [3];
    logic              neg_d_reg  [3];
    logic              zero_d_reg;

    logic [SW-1:0]     rs_reg   [SQ_STEPS+1];
    logic [SW-1:0]     rr_reg   [SQ_STEPS+1];
    logic [NW-1:0]     rm_reg   [SQ_STEPS+1][3];
    logic              rn_reg   [SQ_STEPS+1][3];
    logic              rz_reg   [SQ_STEPS+1];

    logic [LW-1:0]     len;
    logic [DW-1:0]     dv_d_reg [QB+1];
    logic [RW-1:0]     dv_r_reg [QB+1][3];
    logic [QB-1:0]     dv_q_reg [QB+1][3];
    logic              dv_n_reg [QB+1][3];
    logic              dv_z_reg [QB+1];

    assign len = rr_reg[SQ_STEPS][LW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NORM_LAT; k++)
                vld_reg[k] <= 1'b0;
        end
        else if (en)
        begin
            vld_reg[0] <= in_valid;
            for (int k = 1; k < NORM_LAT; k++)
                vld_reg[k] <= vld_reg[k-1];
        end
    end

    assign out_valid = vld_reg[NORM_LAT-1];

    // magnitudes and signs
    always_comb
    begin
        for (int i = 0; i < 3; i++)
            mag_a_next[i] = in_vec[i][VW-1] ? MW'(-in_vec[i]) : MW'(in_vec[i]);
    end

    // leading one of the largest magnitude
    always_comb
    begin
        or_a       = mag_a_reg[0] | mag_a_reg[1] | mag_a_reg[2];
        pos_b_next = '0;
        for (int i = 0; i < MW; i++)
            if (or_a[i])
                pos_b_next = PW'(i);
    end

    always_comb
    begin
        for (int i = 0; i < 3; i++)
            if (pos_b_reg > PW'(NTOP))
                shf_c[i] = mag_b_reg[i] >> (pos_b_reg - PW'(NTOP));
            else
                shf_c[i] = mag_b_reg[i] << (PW'(NTOP) - pos_b_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                mag_a_reg[i] <= mag_a_next[i];
                neg_a_reg[i] <= in_vec[i][VW-1];
                mag_b_reg[i] <= mag_a_reg[i];
                neg_b_reg[i] <= neg_a_reg[i];
                nm_c_reg[i]  <= shf_c[i][NW-1:0];
                neg_c_reg[i] <= neg_b_reg[i];
                sqr_d_reg[i] <= (2*NW)'(nm_c_reg[i]) * (2*NW)'(nm_c_reg[i]);
                nm_d_reg[i]  <= nm_c_reg[i];
                neg_d_reg[i] <= neg_c_reg[i];
                rm_reg[0][i] <= nm_d_reg[i];
                rn_reg[0][i] <= neg_d_reg[i];
            end
            pos_b_reg  <= pos_b_next;
            zero_b_reg <= (or_a == '0);
            zero_c_reg <= zero_b_reg;
            zero_d_reg <= zero_c_reg;
            rs_reg[0]  <= SW'(sqr_d_reg[0]) + SW'(sqr_d_reg[1]) + SW'(sqr_d_reg[2]);
            rr_reg[0]  <= '0;
            rz_reg[0]  <= zero_d_reg;
        end
    end

    // square root, one result bit per stage
    for (genvar k = 0; k < SQ_STEPS; k++)
    begin : g_root
        localparam logic [SW-1:0] BIT = SW'(1) << (SW - 2 - 2*k);
        logic [SW-1:0] trial;
        assign trial = rr_reg[k] + BIT;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (rs_reg[k] >= trial)
                begin
                    rs_reg[k+1] <= rs_reg[k] - trial;
                    rr_reg[k+1] <= (rr_reg[k] >> 1) + BIT;
                end
                else
                begin
                    rs_reg[k+1] <= rs_reg[k];
                    rr_reg[k+1] <= rr_reg[k] >> 1;
                end
                rm_reg[k+1] <= rm_reg[k];
                rn_reg[k+1] <= rn_reg[k];
                rz_reg[k+1] <= rz_reg[k];
            end
        end
    end

    // divide setup: round half up of m * 2^16 / len
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_d_reg[0] <= {len, 1'b0};
            dv_z_reg[0] <= rz_reg[SQ_STEPS];
            for (int i = 0; i < 3; i++)
            begin
                dv_r_reg[0][i] <= RW'({rm_reg[SQ_STEPS][i], QB'(0)}) + RW'(len);
                dv_q_reg[0][i] <= '0;
                dv_n_reg[0][i] <= rn_reg[SQ_STEPS][i];
            end
        end
    end

    // restoring divide, one quotient bit per stage
    for (genvar j = 0; j < QB; j++)
    begin : g_div
        localparam int B = QB - 1 - j;
        logic [RW-1:0] trial;
        assign trial = RW'(dv_d_reg[j]) << B;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int i = 0; i < 3; i++)
                begin
                    if (dv_r_reg[j][i] >= trial)
                    begin
                        dv_r_reg[j+1][i] <= dv_r_reg[j][i] - trial;
                        dv_q_reg[j+1][i] <= dv_q_reg[j][i] | (QB'(1) << B);
                    end
                    else
                    begin
                        dv_r_reg[j+1][i] <= dv_r_reg[j][i];
                        dv_q_reg[j+1][i] <= dv_q_reg[j][i];
                    end
                    dv_n_reg[j+1][i] <= dv_n_reg[j][i];
                end
                dv_d_reg[j+1] <= dv_d_reg[j];
                dv_z_reg[j+1] <= dv_z_reg[j];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
                if (dv_z_reg[QB])
                    out_vec[i] <= '0;
                else if (dv_n_reg[QB][i])
                    out_vec[i] <= -$signed(UW'(dv_q_reg[QB][i]));
                else
                    out_vec[i] <= $signed(UW'(dv_q_reg[QB][i]));
        end
    end

endmodule

/* src/look_at_view_matrix.sv */
// look-at view matrix: top level pipeline with two normalize units
// depends on lavm_pkg and lavm_norm
//
// channel   dir   fields (low bit up)
// s_*       in    eye_x/y/z, aim_x/y/z, upward_x/y/z, 32 bits each
// m_*       out   right, true_up, back (18 bits x/y/z), shift_x/y/z (32 bits)
//
// one transfer per cycle in each direction while the output is not stalled;
// the two square root and divide pipelines make up most of the pipeline depth
// rst_n clears the valid bits only, data registers are not reset
// a stalled output freezes every stage at once, nothing is lost or repeated
module look_at_view_matrix (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // eye_x, eye_y, eye_z, aim_x, aim_y, aim_z, upward_x, upward_y, upward_z
    input  logic [lavm_pkg::IN_W-1:0]     s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // right_x/y/z, true_up_x/y/z, back_x/y/z, shift_x, shift_y, shift_z, pad
    output logic [lavm_pkg::OUT_W-1:0]    m_tdata
);
    import lavm_pkg::*;

    localparam int AW = 52;
    localparam int TW = 37;
    localparam logic signed [AW-1:0] HALF_A = AW'(32768);
    localparam logic signed [AW-1:0] MAX_A  = AW'(64'sh7fffffff);
    localparam logic signed [AW-1:0] MIN_A  = -AW'(64'sh80000000);
    localparam logic signed [TW-1:0] HALF_T = TW'(32768);
    localparam logic signed [TW-1:0] ONE_T  = TW'(65536);

    function automatic logic signed [CW-1:0] sat_r16(input logic signed [AW-1:0] v);
        logic signed [AW-1:0] w;
        w = (v + HALF_A) >>> 16;
        if (w > MAX_A)
            return CW'(MAX_A);
        if (w < MIN_A)
            return CW'(MIN_A);
        return CW'(w);
    endfunction

    function automatic logic signed [UW-1:0] clamp_r16(input logic signed [TW-1:0] v);
        logic signed [TW-1:0] w;
        w = (v + HALF_T) >>> 16;
        if (w > ONE_T)
            return UW'(ONE_T);
        if (w < -ONE_T)
            return UW'(-ONE_T);
        return UW'(w);
    endfunction

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg, v6_reg, v7_reg, v8_reg;
    logic n1_valid, n2_valid;

    logic signed [CW-1:0]   eye_in [3];
    logic signed [CW-1:0]   aim_in [3];
    logic signed [CW-1:0]   up_in  [3];

    logic signed [CW-1:0]   eye1_reg [3];
    logic signed [CW-1:0]   up1_reg  [3];
    logic signed [CW:0]     d1_reg   [3];
    logic signed [VW-1:0]   n1_in    [3];
    logic signed [UW-1:0]   dir_n    [3];

    logic signed [CW-1:0]   eye_da_reg [NORM_LAT][3];
    logic signed [CW-1:0]   up_da_reg  [NORM_LAT][3];

    logic signed [VW-1:0]   pu2_reg  [6];
    logic signed [CW-1:0]   eye2_reg [3];
    logic signed [UW-1:0]   dir2_reg [3];
    logic signed [VW-1:0]   rr3_reg  [3];
    logic signed [CW-1:0]   eye3_reg [3];
    logic signed [UW-1:0]   dir3_reg [3];
    logic signed [UW-1:0]   right_n  [3];

    logic signed [CW-1:0]   eye_db_reg [NORM_LAT][3];
    logic signed [UW-1:0]   dir_db_reg [NORM_LAT][3];

    logic signed [2*UW-1:0] rd4_reg  [6];
    logic signed [VW-1:0]   re4_reg  [3];
    logic signed [VW-1:0]   de4_reg  [3];
    logic signed [CW-1:0]   eye4_reg [3];
    logic signed [UW-1:0]   dir4_reg [3];
    logic signed [UW-1:0]   rt4_reg  [3];

    logic signed [TW-1:0]   tr5_reg  [3];
    logic signed [AW-1:0]   rdot5_reg, ddot5_reg;
    logic signed [CW-1:0]   eye5_reg [3];
    logic signed [UW-1:0]   dir5_reg [3];
    logic signed [UW-1:0]   rt5_reg  [3];

    logic signed [UW-1:0]   tu6_reg  [3];
    logic signed [CW-1:0]   sx6_reg, sz6_reg;
    logic signed [CW-1:0]   eye6_reg [3];
    logic signed [UW-1:0]   dir6_reg [3];
    logic signed [UW-1:0]   rt6_reg  [3];

    logic signed [VW-1:0]   te7_reg  [3];
    logic signed [UW-1:0]   tu7_reg  [3];
    logic signed [CW-1:0]   sx7_reg, sz7_reg;
    logic signed [UW-1:0]   dir7_reg [3];
    logic signed [UW-1:0]   rt7_reg  [3];

    logic signed [AW-1:0]   tdot8_reg;
    logic signed [UW-1:0]   tu8_reg  [3];
    logic signed [CW-1:0]   sx8_reg, sz8_reg;
    logic signed [UW-1:0]   dir8_reg [3];
    logic signed [UW-1:0]   rt8_reg  [3];

    logic [OUT_W-1:0]       m_tdata_next;
    logic [OUT_W-1:0]       m_tdata_reg;
    logic                   m_tvalid_reg;

    assign en       = !m_tvalid_reg || m_tready;
    assign s_tready = en;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            eye_in[i] = $signed(s_tdata[CW*i +: CW]);
            aim_in[i] = $signed(s_tdata[CW*(3+i) +: CW]);
            up_in[i]  = $signed(s_tdata[CW*(6+i) +: CW]);
            n1_in[i]  = VW'(d1_reg[i]);
        end
    end

    lavm_norm u_dir_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v1_reg),
        .in_vec    (n1_in),
        .out_valid (n1_valid),
        .out_vec   (dir_n)
    );

    lavm_norm u_right_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v3_reg),
        .in_vec    (rr3_reg),
        .out_valid (n2_valid),
        .out_vec   (right_n)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg       <= 1'b0;
            v2_reg       <= 1'b0;
            v3_reg       <= 1'b0;
            v4_reg       <= 1'b0;
            v5_reg       <= 1'b0;
            v6_reg       <= 1'b0;
            v7_reg       <= 1'b0;
            v8_reg       <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg       <= s_tvalid;
            v2_reg       <= n1_valid;
            v3_reg       <= v2_reg;
            v4_reg       <= n2_valid;
            v5_reg       <= v4_reg;
            v6_reg       <= v5_reg;
            v7_reg       <= v6_reg;
            v8_reg       <= v7_reg;
            m_tvalid_reg <= v8_reg;
        end
    end

    always_comb
    begin
        m_tdata_next = '0;
        for (int i = 0; i < 3; i++)
        begin
            m_tdata_next[UW*i +: UW]     = rt8_reg[i];
            m_tdata_next[UW*(3+i) +: UW] = tu8_reg[i];
            m_tdata_next[UW*(6+i) +: UW] = -dir8_reg[i];
        end
        m_tdata_next[9*UW +: CW]        = sx8_reg;
        m_tdata_next[9*UW + CW +: CW]   = sat_r16(-tdot8_reg);
        m_tdata_next[9*UW + 2*CW +: CW] = sz8_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                eye1_reg[i] <= eye_in[i];
                up1_reg[i]  <= up_in[i];
                d1_reg[i]   <= aim_in[i] - eye_in[i];

                eye_da_reg[0][i] <= eye1_reg[i];
                up_da_reg[0][i]  <= up1_reg[i];
                for (int k = 1; k < NORM_LAT; k++)
                begin
                    eye_da_reg[k][i] <= eye_da_reg[k-1][i];
                    up_da_reg[k][i]  <= up_da_reg[k-1][i];
                end

                eye2_reg[i] <= eye_da_reg[NORM_LAT-1][i];
                dir2_reg[i] <= dir_n[i];
                eye3_reg[i] <= eye2_reg[i];
                dir3_reg[i] <= dir2_reg[i];

                eye_db_reg[0][i] <= eye3_reg[i];
                dir_db_reg[0][i] <= dir3_reg[i];
                for (int k = 1; k < NORM_LAT; k++)
                begin
                    eye_db_reg[k][i] <= eye_db_reg[k-1][i];
                    dir_db_reg[k][i] <= dir_db_reg[k-1][i];
                end

                eye4_reg[i] <= eye_db_reg[NORM_LAT-1][i];
                dir4_reg[i] <= dir_db_reg[NORM_LAT-1][i];
                rt4_reg[i]  <= right_n[i];
                re4_reg[i]  <= right_n[i] * eye_db_reg[NORM_LAT-1][i];
                de4_reg[i]  <= dir_db_reg[NORM_LAT-1][i] * eye_db_reg[NORM_LAT-1][i];

                eye5_reg[i] <= eye4_reg[i];
                dir5_reg[i] <= dir4_reg[i];
                rt5_reg[i]  <= rt4_reg[i];

                tu6_reg[i]  <= clamp_r16(tr5_reg[i]);
                eye6_reg[i] <= eye5_reg[i];
                dir6_reg[i] <= dir5_reg[i];
                rt6_reg[i]  <= rt5_reg[i];

                te7_reg[i]  <= tu6_reg[i] * eye6_reg[i];
                tu7_reg[i]  <= tu6_reg[i];
                dir7_reg[i] <= dir6_reg[i];
                rt7_reg[i]  <= rt6_reg[i];

                tu8_reg[i]  <= tu7_reg[i];
                dir8_reg[i] <= dir7_reg[i];
                rt8_reg[i]  <= rt7_reg[i];
            end

            // raw right = dir x up
            pu2_reg[0] <= dir_n[1] * up_da_reg[NORM_LAT-1][2];
            pu2_reg[1] <= dir_n[2] * up_da_reg[NORM_LAT-1][1];
            pu2_reg[2] <= dir_n[2] * up_da_reg[NORM_LAT-1][0];
            pu2_reg[3] <= dir_n[0] * up_da_reg[NORM_LAT-1][2];
            pu2_reg[4] <= dir_n[0] * up_da_reg[NORM_LAT-1][1];
            pu2_reg[5] <= dir_n[1] * up_da_reg[NORM_LAT-1][0];
            rr3_reg[0] <= pu2_reg[0] - pu2_reg[1];
            rr3_reg[1] <= pu2_reg[2] - pu2_reg[3];
            rr3_reg[2] <= pu2_reg[4] - pu2_reg[5];

            // true up = right x dir
            rd4_reg[0] <= right_n[1] * dir_db_reg[NORM_LAT-1][2];
            rd4_reg[1] <= right_n[2] * dir_db_reg[NORM_LAT-1][1];
            rd4_reg[2] <= right_n[2] * dir_db_reg[NORM_LAT-1][0];
            rd4_reg[3] <= right_n[0] * dir_db_reg[NORM_LAT-1][2];
            rd4_reg[4] <= right_n[0] * dir_db_reg[NORM_LAT-1][1];
            rd4_reg[5] <= right_n[1] * dir_db_reg[NORM_LAT-1][0];
            tr5_reg[0] <= rd4_reg[0] - rd4_reg[1];
            tr5_reg[1] <= rd4_reg[2] - rd4_reg[3];
            tr5_reg[2] <= rd4_reg[4] - rd4_reg[5];

            rdot5_reg <= re4_reg[0] + re4_reg[1] + re4_reg[2];
            ddot5_reg <= de4_reg[0] + de4_reg[1] + de4_reg[2];
            sx6_reg   <= sat_r16(-rdot5_reg);
            sz6_reg   <= sat_r16(ddot5_reg);
            sx7_reg   <= sx6_reg;
            sz7_reg   <= sz6_reg;
            tdot8_reg <= te7_reg[0] + te7_reg[1] + te7_reg[2];
            sx8_reg   <= sx7_reg;
            sz8_reg   <= sz7_reg;

            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule
